[hw/rtl/jdis_pkg.sv]
// Shared types and constants for the job dispatcher.
// Holds the controller/datapath command and status structs and the result codes.
// No dependencies.
package jdis_pkg;

   // op field of a request
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // kind field of a result
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_IDLE   = 2'd3;

   // fixed field widths
   localparam int ID_W     = 16;
   localparam int LEN_W    = 16;
   localparam int STEP_W   = 16;
   localparam int TOTAL_W  = 32;
   localparam int SRV_OUT_W = 3;
   localparam int CFG_W    = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic capture;    // latch the accepted request, restart the scan
      logic enq;        // dispatch, queue or drop the latched job and emit
      logic min_step;   // examine one server for the minimum
      logic sub;        // subtract the minimum, record servers that hit zero
      logic none;       // emit the nothing-busy result
      logic complete;   // emit the lowest pending completion
      logic load;       // start the queued job read out of the FIFO
   } cmd_type;

   typedef struct packed {
      logic out_free;      // output register can take a result this cycle
      logic scan_last;     // minimum scan is at the last active server
      logic any_busy;      // scan found at least one busy server
      logic fifo_nonempty;
      logic hit_any;       // completions still pending
      logic hit_single;    // at most one completion pending
   } sts_type;

endpackage

[hw/rtl/jdis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the job FIFO storage. No dependencies.
module jdis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/jdis_ctrl.sv]
// Sequencing state machine for the job dispatcher.
// Drives jdis_pkg::cmd_type to the datapath from jdis_pkg::sts_type and the request handshake.
module jdis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_op,
   input  jdis_pkg::sts_type sts,
   output jdis_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ENQ  = 3'd1;
   localparam logic [2:0] ST_MIN  = 3'd2;
   localparam logic [2:0] ST_SUB  = 3'd3;
   localparam logic [2:0] ST_NONE = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic [2:0] ST_LOAD = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = (req_op == jdis_pkg::OP_ADVANCE) ? ST_MIN : ST_ENQ;
            end
         end
         ST_ENQ: begin
            if (sts.out_free) begin
               cmd.enq  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MIN: begin
            cmd.min_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (!sts.any_busy) begin
               state_in = ST_NONE;
            end else begin
               cmd.sub  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_NONE: begin
            if (sts.out_free) begin
               cmd.none = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.complete = 1'b1;
               // a queued job starts only after its registered RAM read
               if (sts.fifo_nonempty) begin
                  state_in = ST_LOAD;
               end else if (sts.hit_single) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = sts.hit_any ? ST_DONE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/jdis_dp.sv]
// Datapath of the job dispatcher: server registers, job FIFO, minimum scan,
// completion pick and the result register. Uses jdis_pkg and jdis_ram.
module jdis_dp #(
   parameter int MAX_SERVERS = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int WORK_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [jdis_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic [jdis_pkg::ID_W-1:0]         req_job_id,
   input  logic [jdis_pkg::LEN_W-1:0]        req_work_length,
   input  jdis_pkg::cmd_type                 cmd,
   output jdis_pkg::sts_type                 sts,
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_kind,
   output logic [jdis_pkg::SRV_OUT_W-1:0]    rsp_server,
   output logic [jdis_pkg::ID_W-1:0]         rsp_job_id,
   output logic [jdis_pkg::LEN_W-1:0]        rsp_length,
   output logic [jdis_pkg::STEP_W-1:0]       rsp_step,
   output logic [jdis_pkg::TOTAL_W-1:0]      rsp_total,
   output logic                              rsp_last
);

   localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int ACT_W  = $clog2(MAX_SERVERS + 1);
   localparam int CNT_AW = (ACT_W > jdis_pkg::CFG_W) ? ACT_W : jdis_pkg::CFG_W;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = jdis_pkg::ID_W + jdis_pkg::LEN_W;
   localparam logic [jdis_pkg::LEN_W-1:0] LEN_MASK = (WORK_BITS >= jdis_pkg::LEN_W) ?
      {jdis_pkg::LEN_W{1'b1}} : jdis_pkg::LEN_W'((32'd1 << WORK_BITS) - 32'd1);

   // configuration
   logic [jdis_pkg::CFG_W-1:0] csr_ff;
   logic                       csr_dflt_ff;   // set until first write: all servers active
   logic [CNT_AW-1:0]          cfg_x;
   logic [CNT_AW-1:0]          act_cnt;
   logic [MAX_SERVERS-1:0]     act_mask;

   // server state
   logic [WORK_BITS-1:0]       rem_ff  [MAX_SERVERS];
   logic [WORK_BITS-1:0]       rem_in  [MAX_SERVERS];
   logic [jdis_pkg::ID_W-1:0]  sid_ff  [MAX_SERVERS];
   logic [jdis_pkg::ID_W-1:0]  sid_in  [MAX_SERVERS];
   logic [jdis_pkg::LEN_W-1:0] slen_ff [MAX_SERVERS];
   logic [jdis_pkg::LEN_W-1:0] slen_in [MAX_SERVERS];
   logic [MAX_SERVERS-1:0]     busy_ff, busy_in;
   logic [MAX_SERVERS-1:0]     hit_ff, hit_in;

   // latched request and scan state
   logic [jdis_pkg::ID_W-1:0]  job_id_ff, job_id_in;
   logic [jdis_pkg::LEN_W-1:0] job_len_ff, job_len_in;
   logic [SRV_W-1:0]           idx_ff, idx_in;
   logic                       any_ff, any_in;
   logic [WORK_BITS-1:0]       least_ff, least_in;
   logic [SRV_W-1:0]           cur_ff, cur_in;
   logic [jdis_pkg::TOTAL_W-1:0] total_ff, total_in;

   // FIFO
   logic [PTR_W-1:0]           rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [FCNT_W-1:0]          fcnt_ff, fcnt_in;
   logic                       ram_we, ram_re;
   logic [ENTRY_W-1:0]         ram_rdata;

   // result register
   logic                       rvalid_ff, rvalid_in;
   logic [1:0]                 rkind_ff, rkind_in;
   logic [jdis_pkg::SRV_OUT_W-1:0] rsrv_ff, rsrv_in;
   logic [jdis_pkg::ID_W-1:0]  rid_ff, rid_in;
   logic [jdis_pkg::LEN_W-1:0] rlen_ff, rlen_in;
   logic [jdis_pkg::STEP_W-1:0] rstep_ff, rstep_in;
   logic [jdis_pkg::TOTAL_W-1:0] rtotal_ff, rtotal_in;
   logic                       rlast_ff, rlast_in;

   // search helpers
   logic                       idle_found;
   logic [SRV_W-1:0]           idle_sel;
   logic [SRV_W-1:0]           hit_sel;
   logic [WORK_BITS-1:0]       diff [MAX_SERVERS];
   logic                       out_free;
   logic [PTR_W-1:0]           rptr_inc, wptr_inc;

   // active server count: zero acts as one, large values clamp
   always_comb begin
      cfg_x = CNT_AW'(csr_ff);
      if (csr_dflt_ff) begin
         act_cnt = CNT_AW'(MAX_SERVERS);
      end else if (cfg_x == '0) begin
         act_cnt = CNT_AW'(1);
      end else if (cfg_x > CNT_AW'(MAX_SERVERS)) begin
         act_cnt = CNT_AW'(MAX_SERVERS);
      end else begin
         act_cnt = cfg_x;
      end
      for (int s = 0; s < MAX_SERVERS; s++) begin
         act_mask[s] = (CNT_AW'(s) < act_cnt);
      end
   end

   // lowest idle active server, lowest pending completion
   always_comb begin
      idle_found = 1'b0;
      idle_sel   = '0;
      hit_sel    = '0;
      for (int s = MAX_SERVERS - 1; s >= 0; s--) begin
         if (act_mask[s] && !busy_ff[s]) begin
            idle_found = 1'b1;
            idle_sel   = SRV_W'(s);
         end
         if (hit_ff[s]) begin
            hit_sel = SRV_W'(s);
         end
      end
   end

   assign out_free = !rvalid_ff || rsp_tready;
   assign rptr_inc = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
   assign wptr_inc = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);

   always_comb begin
      sts.out_free      = out_free;
      sts.scan_last     = ((CNT_AW'(idx_ff) + CNT_AW'(1)) == act_cnt);
      sts.any_busy      = any_ff;
      sts.fifo_nonempty = (fcnt_ff != '0);
      sts.hit_any       = |hit_ff;
      sts.hit_single    = ((hit_ff & (hit_ff - MAX_SERVERS'(1))) == '0);
   end

   always_comb begin
      rem_in     = rem_ff;
      sid_in     = sid_ff;
      slen_in    = slen_ff;
      busy_in    = busy_ff;
      hit_in     = hit_ff;
      job_id_in  = job_id_ff;
      job_len_in = job_len_ff;
      idx_in     = idx_ff;
      any_in     = any_ff;
      least_in   = least_ff;
      cur_in     = cur_ff;
      total_in   = total_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      fcnt_in    = fcnt_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      rvalid_in  = rvalid_ff && !rsp_tready;
      rkind_in   = rkind_ff;
      rsrv_in    = rsrv_ff;
      rid_in     = rid_ff;
      rlen_in    = rlen_ff;
      rstep_in   = rstep_ff;
      rtotal_in  = rtotal_ff;
      rlast_in   = rlast_ff;
      for (int s = 0; s < MAX_SERVERS; s++) begin
         diff[s] = rem_ff[s] - least_ff;
      end

      if (cmd.capture) begin
         job_id_in  = req_job_id;
         job_len_in = req_work_length & LEN_MASK;
         idx_in     = '0;
         any_in     = 1'b0;
      end

      if (cmd.enq) begin
         rvalid_in = 1'b1;
         rkind_in  = jdis_pkg::KIND_ACCEPT;
         rsrv_in   = '0;
         rid_in    = job_id_ff;
         rlen_in   = job_len_ff;
         rstep_in  = '0;
         rtotal_in = total_ff;
         rlast_in  = 1'b1;
         // queued jobs keep FIFO order even if a server is idle
         if (fcnt_ff == '0 && idle_found) begin
            busy_in[idle_sel] = 1'b1;
            sid_in[idle_sel]  = job_id_ff;
            slen_in[idle_sel] = job_len_ff;
            rem_in[idle_sel]  = WORK_BITS'(job_len_ff);
            rsrv_in           = jdis_pkg::SRV_OUT_W'(idle_sel);
         end else if (fcnt_ff == FCNT_W'(QUEUE_DEPTH)) begin
            rkind_in = jdis_pkg::KIND_DROP;
         end else begin
            ram_we  = 1'b1;
            wptr_in = wptr_inc;
            fcnt_in = fcnt_ff + FCNT_W'(1);
         end
      end

      if (cmd.min_step) begin
         if (busy_ff[idx_ff] && (!any_ff || rem_ff[idx_ff] < least_ff)) begin
            least_in = rem_ff[idx_ff];
            any_in   = 1'b1;
         end
         idx_in = idx_ff + SRV_W'(1);
      end

      if (cmd.sub) begin
         for (int s = 0; s < MAX_SERVERS; s++) begin
            hit_in[s] = 1'b0;
            if (busy_ff[s] && act_mask[s]) begin
               rem_in[s] = diff[s];
               hit_in[s] = (diff[s] == '0);
            end
         end
      end

      if (cmd.none) begin
         rvalid_in = 1'b1;
         rkind_in  = jdis_pkg::KIND_IDLE;
         rsrv_in   = '0;
         rid_in    = '0;
         rlen_in   = '0;
         rstep_in  = '0;
         rtotal_in = total_ff;
         rlast_in  = 1'b1;
      end

      if (cmd.complete) begin
         total_in        = total_ff + jdis_pkg::TOTAL_W'(slen_ff[hit_sel]);
         rvalid_in       = 1'b1;
         rkind_in        = jdis_pkg::KIND_DONE;
         rsrv_in         = jdis_pkg::SRV_OUT_W'(hit_sel);
         rid_in          = sid_ff[hit_sel];
         rlen_in         = slen_ff[hit_sel];
         rstep_in        = jdis_pkg::STEP_W'(least_ff);
         rtotal_in       = total_in;
         rlast_in        = sts.hit_single;
         hit_in[hit_sel] = 1'b0;
         cur_in          = hit_sel;
         if (fcnt_ff != '0) begin
            ram_re  = 1'b1;
            rptr_in = rptr_inc;
            fcnt_in = fcnt_ff - FCNT_W'(1);
         end else begin
            busy_in[hit_sel] = 1'b0;
            rem_in[hit_sel]  = '0;
         end
      end

      if (cmd.load) begin
         busy_in[cur_ff] = 1'b1;
         sid_in[cur_ff]  = ram_rdata[ENTRY_W-1:jdis_pkg::LEN_W];
         slen_in[cur_ff] = ram_rdata[jdis_pkg::LEN_W-1:0];
         rem_in[cur_ff]  = WORK_BITS'(ram_rdata[jdis_pkg::LEN_W-1:0]);
      end
   end

   jdis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data ({job_id_ff, job_len_ff}),
      .rd_en   (ram_re),
      .rd_addr (rptr_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff      <= '0;
         csr_dflt_ff <= 1'b1;
         busy_ff     <= '0;
         hit_ff      <= '0;
         idx_ff      <= '0;
         any_ff      <= 1'b0;
         total_ff    <= '0;
         rptr_ff     <= '0;
         wptr_ff     <= '0;
         fcnt_ff     <= '0;
         rvalid_ff   <= 1'b0;
         for (int s = 0; s < MAX_SERVERS; s++) begin
            rem_ff[s] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            csr_ff      <= csr_wr_data;
            csr_dflt_ff <= 1'b0;
         end
         busy_ff   <= busy_in;
         hit_ff    <= hit_in;
         idx_ff    <= idx_in;
         any_ff    <= any_in;
         total_ff  <= total_in;
         rptr_ff   <= rptr_in;
         wptr_ff   <= wptr_in;
         fcnt_ff   <= fcnt_in;
         rvalid_ff <= rvalid_in;
         rem_ff    <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff     <= sid_in;
      slen_ff    <= slen_in;
      job_id_ff  <= job_id_in;
      job_len_ff <= job_len_in;
      least_ff   <= least_in;
      cur_ff     <= cur_in;
      rkind_ff   <= rkind_in;
      rsrv_ff    <= rsrv_in;
      rid_ff     <= rid_in;
      rlen_ff    <= rlen_in;
      rstep_ff   <= rstep_in;
      rtotal_ff  <= rtotal_in;
      rlast_ff   <= rlast_in;
   end

   assign rsp_valid  = rvalid_ff;
   assign rsp_kind   = rkind_ff;
   assign rsp_server = rsrv_ff;
   assign rsp_job_id = rid_ff;
   assign rsp_length = rlen_ff;
   assign rsp_step   = rstep_ff;
   assign rsp_total  = rtotal_ff;
   assign rsp_last   = rlast_ff;

endmodule

[hw/rtl/job_dispatch_to_idle_servers_top.sv]
// Job dispatcher top level: a pool of identical servers fed from one job FIFO.
// Request stream: tuser = op (enqueue or advance), tdata = job id and work length.
// Result stream: tuser = result kind, tlast marks the final result of a request.
// An enqueue yields one result: started on the lowest idle server, queued, or
// dropped because the queue is full. An advance takes the least remaining work
// among busy servers off every busy server and reports each server that reached
// zero in server order; such a server then takes the next queued job or goes
// idle. With no busy server an advance yields one nothing-busy result. One
// request at a time. An enqueue reaches the result register from the ENQ state
// once that register is free. An advance scans the active servers one at a
// time for the minimum (the shared compare unit), subtracts, then emits one
// completion at a time, loading a queued job after a registered FIFO RAM read.
// A new request is taken while the previous result still waits in the result
// register; a stalled receiver holds the result and halts the sequencer.
// Reset empties the queue, idles all servers, clears the total and makes all
// servers active; the csr register can be written at any idle time.
module job_dispatch_to_idle_servers_top #(
   parameter int MAX_SERVERS = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int WORK_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [jdis_pkg::CFG_W-1:0]         csr_wr_data,  // servers_in_use
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [jdis_pkg::REQ_DATA_W-1:0]    req_tdata,    // job_id, work_length
   input  logic [0:0]                         req_tuser,    // op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // server, done_job_id, done_length, elapsed_step, total_done, zero pad
   output logic [jdis_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,    // kind
   output logic                               rsp_tlast
);

   localparam int PAD_W = jdis_pkg::RSP_DATA_W - jdis_pkg::SRV_OUT_W - jdis_pkg::ID_W
                          - jdis_pkg::LEN_W - jdis_pkg::STEP_W - jdis_pkg::TOTAL_W;

   jdis_pkg::cmd_type cmd;
   jdis_pkg::sts_type sts;

   logic [jdis_pkg::SRV_OUT_W-1:0] rsp_server;
   logic [jdis_pkg::ID_W-1:0]      rsp_job_id;
   logic [jdis_pkg::LEN_W-1:0]     rsp_length;
   logic [jdis_pkg::STEP_W-1:0]    rsp_step;
   logic [jdis_pkg::TOTAL_W-1:0]   rsp_total;

   jdis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   jdis_dp #(
      .MAX_SERVERS (MAX_SERVERS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORK_BITS   (WORK_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_job_id      (req_tdata[jdis_pkg::ID_W-1:0]),
      .req_work_length (req_tdata[jdis_pkg::REQ_DATA_W-1:jdis_pkg::ID_W]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_kind        (rsp_tuser),
      .rsp_server      (rsp_server),
      .rsp_job_id      (rsp_job_id),
      .rsp_length      (rsp_length),
      .rsp_step        (rsp_step),
      .rsp_total       (rsp_total),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_total, rsp_step, rsp_length, rsp_job_id, rsp_server};

endmodule
